@@ rtl/ptog_pkg.sv @@
// Shared types, constants and helpers of the point to occupancy grid block.
package ptog_pkg;

    // Grid geometry.
    localparam int MAX_SIDE   = 512;
    localparam int SIDE_W     = $clog2(MAX_SIDE);
    localparam int DIM_W      = $clog2(MAX_SIDE + 1);
    localparam int AREA_W     = 2 * DIM_W;
    localparam int GRID_CELLS = MAX_SIDE * MAX_SIDE;
    localparam int CELL_W     = $clog2(GRID_CELLS);

    // Occupancy storage is packed into words.
    localparam int WORD_W  = (GRID_CELLS >= 128) ? 64 : 2;
    localparam int WBIT_W  = $clog2(WORD_W);
    localparam int WORDS   = (GRID_CELLS + WORD_W - 1) / WORD_W;
    localparam int WORD_AW = $clog2(WORDS);

    // Field widths.
    localparam int CMD_W    = 2;
    localparam int COORD_W  = 32;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int CSIZE_W  = 31;
    localparam int MAPDIM_W = 10;
    localparam int IDX_W    = 18;
    localparam int VAL_W    = 8;
    localparam int COUNT_W  = 19;

    // Divider geometry.
    localparam int DIV_W = CSIZE_W + SIDE_W;
    localparam int CNT_W = $clog2(SIDE_W + 1);

    // Configuration port.
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CELL_SIZE  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MAP_WIDTH  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MAP_HEIGHT = 3'd4;

    localparam logic [CSIZE_W-1:0]  CELL_SIZE_RST = 31'd65536;
    localparam logic [MAPDIM_W-1:0] MAP_DIM_RST   = 10'd512;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_POINT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Cell values and count limit.
    localparam logic [VAL_W-1:0]   CELL_OCCUPIED = 8'd0;
    localparam logic [VAL_W-1:0]   CELL_UNKNOWN  = 8'd128;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic [IDX_W-1:0]          read_index;
    } t_in_item;

    typedef struct packed {
        logic                in_map;
        logic                newly_occupied;
        logic [IDX_W-1:0]    cell_index;
        logic [VAL_W-1:0]    cell_value;
        logic [COUNT_W-1:0]  marked_cells;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic [CSIZE_W-1:0]        cell_size;
        logic [MAPDIM_W-1:0]       map_width;
        logic [MAPDIM_W-1:0]       map_height;
    } t_cfg;

    typedef struct packed {
        logic               start;
        logic [COORD_W-1:0] dividend;
        logic [CSIZE_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic              over;
        logic [SIDE_W-1:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic               we;
        logic [WORD_AW-1:0] waddr;
        logic [WORD_W-1:0]  wdata;
        logic               re;
        logic [WORD_AW-1:0] raddr;
    } t_mem_req;

    // Map dimension limited to the grid side.
    function automatic logic [DIM_W-1:0] eff_side(input logic [MAPDIM_W-1:0] s);
        if (32'(s) > 32'(MAX_SIDE)) begin
            return DIM_W'(MAX_SIDE);
        end
        return DIM_W'(s);
    endfunction

endpackage

@@ rtl/ptog_regs.sv @@
// Configuration register file behind the APB-style port.
module ptog_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ptog_pkg::APB_AW-1:0]   paddr,
    input  logic [ptog_pkg::APB_DW-1:0]   pwdata,
    output logic [ptog_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output ptog_pkg::t_cfg                o_cfg
);

    ptog_pkg::t_cfg                       r_cfg;
    ptog_pkg::t_cfg                       n_cfg;
    logic [ptog_pkg::REG_IDX_W-1:0]       reg_idx;
    logic                                 wr_en;

    assign reg_idx = paddr[ptog_pkg::APB_AW-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                ptog_pkg::REG_ORIGIN_X:   n_cfg.origin_x   = pwdata;
                ptog_pkg::REG_ORIGIN_Y:   n_cfg.origin_y   = pwdata;
                ptog_pkg::REG_CELL_SIZE:  n_cfg.cell_size  = pwdata[ptog_pkg::CSIZE_W-1:0];
                ptog_pkg::REG_MAP_WIDTH:  n_cfg.map_width  = pwdata[ptog_pkg::MAPDIM_W-1:0];
                ptog_pkg::REG_MAP_HEIGHT: n_cfg.map_height = pwdata[ptog_pkg::MAPDIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            ptog_pkg::REG_ORIGIN_X:   prdata = r_cfg.origin_x;
            ptog_pkg::REG_ORIGIN_Y:   prdata = r_cfg.origin_y;
            ptog_pkg::REG_CELL_SIZE:  prdata = ptog_pkg::APB_DW'(r_cfg.cell_size);
            ptog_pkg::REG_MAP_WIDTH:  prdata = ptog_pkg::APB_DW'(r_cfg.map_width);
            ptog_pkg::REG_MAP_HEIGHT: prdata = ptog_pkg::APB_DW'(r_cfg.map_height);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x   <= '0;
            r_cfg.origin_y   <= '0;
            r_cfg.cell_size  <= ptog_pkg::CELL_SIZE_RST;
            r_cfg.map_width  <= ptog_pkg::MAP_DIM_RST;
            r_cfg.map_height <= ptog_pkg::MAP_DIM_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

@@ rtl/ptog_div.sv @@
// Iterative restoring divider that yields a grid coordinate or flags an overflow.
module ptog_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ptog_pkg::t_div_req i_req,
    output ptog_pkg::t_div_rsp o_rsp
);

    logic                                r_busy,  n_busy;
    logic                                r_done,  n_done;
    logic                                r_over,  n_over;
    logic [ptog_pkg::COORD_W-1:0]        r_rem,   n_rem;
    logic [ptog_pkg::DIV_W-1:0]          r_div,   n_div;
    logic [ptog_pkg::CNT_W-1:0]          r_cnt,   n_cnt;
    logic [ptog_pkg::SIDE_W-1:0]         r_quot,  n_quot;
    logic                                ge;
    logic                                first_step;

    // One compare and subtract per cycle; the first step only checks that the
    // quotient fits the grid side.
    assign ge         = ptog_pkg::DIV_W'(r_rem) >= r_div;
    assign first_step = r_cnt == ptog_pkg::CNT_W'(ptog_pkg::SIDE_W);

    assign o_rsp.done = r_done;
    assign o_rsp.over = r_over;
    assign o_rsp.quot = r_quot;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_over = r_over;
        n_rem  = r_rem;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_quot = r_quot;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_over = 1'b0;
            n_rem  = i_req.dividend;
            n_div  = {i_req.divisor, {ptog_pkg::SIDE_W{1'b0}}};
            n_cnt  = ptog_pkg::CNT_W'(ptog_pkg::SIDE_W);
            n_quot = '0;
        end else if (r_busy) begin
            if (first_step && ge) begin
                n_busy = 1'b0;
                n_done = 1'b1;
                n_over = 1'b1;
            end else begin
                if (ge) begin
                    n_rem = r_rem - ptog_pkg::COORD_W'(r_div);
                end
                n_quot = (r_quot << 1) | ptog_pkg::SIDE_W'(ge);
                n_div  = r_div >> 1;
                if (r_cnt == '0) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_over <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_over <= n_over;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_cnt  <= n_cnt;
        r_quot <= n_quot;
    end

endmodule

@@ rtl/ptog_mem.sv @@
// Word-wide occupancy bit store with one write port and one registered read port.
module ptog_mem (
    input  logic                         i_clk,
    input  ptog_pkg::t_mem_req           i_req,
    output logic [ptog_pkg::WORD_W-1:0]  o_rdata
);

    logic [ptog_pkg::WORD_W-1:0] r_mem [ptog_pkg::WORDS];
    logic [ptog_pkg::WORD_W-1:0] r_rdata;

    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

endmodule

@@ rtl/point_to_occupancy_grid.sv @@
// Point cloud to 2D occupancy grid projection: top level with the command sequencer.
// A point runs the shared divider once per axis, then forms the cell index and does a
// read-modify-write of its occupancy word; a point off the map ends early. A read checks
// the index and reads the word; a clear writes zero to every word. Throughput: one item at a
// time, the next is taken in the cycle after the result registers. Reset (synchronous, active
// low) starts a clearing pass over all WORDS words that holds off items; configuration writes are taken throughout.
module point_to_occupancy_grid (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Item input channel.
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  ptog_pkg::t_in_item            i_in_item,
    // Result output channel.
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output ptog_pkg::t_out_item           o_out_item,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ptog_pkg::APB_AW-1:0]   paddr,
    input  logic [ptog_pkg::APB_DW-1:0]   pwdata,
    output logic [ptog_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    // Sequencer states.
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CLR   = 4'd1;
    localparam logic [3:0] ST_SETUP = 4'd2;
    localparam logic [3:0] ST_DIV   = 4'd3;
    localparam logic [3:0] ST_INDEX = 4'd4;
    localparam logic [3:0] ST_RCHK  = 4'd5;
    localparam logic [3:0] ST_RD    = 4'd6;
    localparam logic [3:0] ST_WR    = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    localparam int PROD_W = ptog_pkg::SIDE_W + ptog_pkg::DIM_W + 1;
    localparam int RCMP_W = ptog_pkg::AREA_W + ptog_pkg::IDX_W;

    ptog_pkg::t_cfg                          cfg;
    ptog_pkg::t_div_req                      div_req;
    ptog_pkg::t_div_rsp                      div_rsp;
    ptog_pkg::t_mem_req                      mem_req;
    logic [ptog_pkg::WORD_W-1:0]             mem_rdata;

    logic [3:0]                              r_state,     n_state;
    logic [ptog_pkg::CMD_W-1:0]              r_cmd,       n_cmd;
    logic signed [ptog_pkg::COORD_W-1:0]     r_px,        n_px;
    logic signed [ptog_pkg::COORD_W-1:0]     r_py,        n_py;
    logic [ptog_pkg::IDX_W-1:0]              r_ridx,      n_ridx;
    logic                                    r_axis,      n_axis;
    logic [ptog_pkg::SIDE_W-1:0]             r_gx,        n_gx;
    logic [ptog_pkg::CELL_W-1:0]             r_cidx,      n_cidx;
    ptog_pkg::t_out_item                     r_res,       n_res;
    logic [ptog_pkg::COUNT_W-1:0]            r_count,     n_count;
    logic [ptog_pkg::WORD_AW-1:0]            r_clr_addr,  n_clr_addr;
    logic                                    r_clr_reply, n_clr_reply;
    logic                                    r_out_valid, n_out_valid;
    ptog_pkg::t_out_item                     r_out,       n_out;

    logic [ptog_pkg::DIM_W-1:0]              w_eff;
    logic [ptog_pkg::DIM_W-1:0]              h_eff;
    logic [ptog_pkg::DIM_W-1:0]              limit;
    logic signed [ptog_pkg::DIFF_W-1:0]      diff;
    logic                                    quot_ok;
    logic [ptog_pkg::AREA_W-1:0]             area;
    logic                                    rd_ok;
    logic [PROD_W-1:0]                       lin_idx;
    logic [ptog_pkg::WORD_AW-1:0]            word_addr;
    logic                                    cur_bit;
    logic                                    in_accept;

    ptog_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ptog_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    ptog_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // Map dimensions above the grid side are clipped to it.
    assign w_eff = ptog_pkg::eff_side(cfg.map_width);
    assign h_eff = ptog_pkg::eff_side(cfg.map_height);
    assign limit = r_axis ? h_eff : w_eff;

    // The offset from the origin is taken on 33 bits so that it never wraps.
    assign diff = r_axis
        ? (ptog_pkg::DIFF_W'(r_py) - ptog_pkg::DIFF_W'(cfg.origin_y))
        : (ptog_pkg::DIFF_W'(r_px) - ptog_pkg::DIFF_W'(cfg.origin_x));

    // The divider quotient is registered, so this compare starts from flops.
    assign quot_ok = ptog_pkg::DIM_W'(div_rsp.quot) < limit;

    // A read index is valid below width times height.
    assign area  = ptog_pkg::AREA_W'(w_eff) * ptog_pkg::AREA_W'(h_eff);
    assign rd_ok = RCMP_W'(r_ridx) < RCMP_W'(area);

    // Row-major index; the Y quotient is still held in the divider.
    assign lin_idx = PROD_W'(div_rsp.quot) * PROD_W'(w_eff) + PROD_W'(r_gx);

    assign word_addr = ptog_pkg::WORD_AW'(r_cidx >> ptog_pkg::WBIT_W);
    assign cur_bit   = mem_rdata[r_cidx[ptog_pkg::WBIT_W-1:0]];

    assign o_in_ready  = r_state == ST_IDLE;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_px        = r_px;
        n_py        = r_py;
        n_ridx      = r_ridx;
        n_axis      = r_axis;
        n_gx        = r_gx;
        n_cidx      = r_cidx;
        n_res       = r_res;
        n_count     = r_count;
        n_clr_addr  = r_clr_addr;
        n_clr_reply = r_clr_reply;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        div_req.start    = 1'b0;
        div_req.dividend = diff[ptog_pkg::COORD_W-1:0];
        div_req.divisor  = cfg.cell_size;

        mem_req.we    = 1'b0;
        mem_req.waddr = word_addr;
        mem_req.wdata = mem_rdata;
        mem_req.re    = 1'b0;
        mem_req.raddr = word_addr;

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_cmd  = i_in_item.command;
                    n_px   = i_in_item.point_x;
                    n_py   = i_in_item.point_y;
                    n_ridx = i_in_item.read_index;
                    n_axis = 1'b0;
                    // Default result is the one for a point off the map.
                    n_res.in_map         = 1'b0;
                    n_res.newly_occupied = 1'b0;
                    n_res.cell_index     = '0;
                    n_res.cell_value     = ptog_pkg::CELL_UNKNOWN;
                    n_res.marked_cells   = '0;
                    unique case (i_in_item.command)
                        ptog_pkg::CMD_POINT: n_state = ST_SETUP;
                        ptog_pkg::CMD_READ:  n_state = ST_RCHK;
                        ptog_pkg::CMD_CLEAR: begin
                            n_count     = '0;
                            n_clr_addr  = '0;
                            n_clr_reply = 1'b1;
                            n_state     = ST_CLR;
                        end
                        default:             n_state = ST_DONE;
                    endcase
                end
            end

            ST_CLR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_clr_addr;
                mem_req.wdata = '0;
                if (r_clr_addr == ptog_pkg::WORD_AW'(ptog_pkg::WORDS - 1)) begin
                    n_clr_reply = 1'b0;
                    n_state     = r_clr_reply ? ST_DONE : ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end

            ST_SETUP: begin
                if (diff[ptog_pkg::DIFF_W-1] || (cfg.cell_size == '0)) begin
                    n_state = ST_DONE;
                end else begin
                    div_req.start = 1'b1;
                    n_state       = ST_DIV;
                end
            end

            ST_DIV: begin
                if (div_rsp.done) begin
                    if (div_rsp.over || !quot_ok) begin
                        n_state = ST_DONE;
                    end else if (!r_axis) begin
                        n_gx    = div_rsp.quot;
                        n_axis  = 1'b1;
                        n_state = ST_SETUP;
                    end else begin
                        n_state = ST_INDEX;
                    end
                end
            end

            ST_INDEX: begin
                n_cidx  = ptog_pkg::CELL_W'(lin_idx);
                n_state = ST_RD;
            end

            ST_RCHK: begin
                n_res.cell_index = r_ridx;
                if (rd_ok) begin
                    n_cidx  = ptog_pkg::CELL_W'(r_ridx);
                    n_state = ST_RD;
                end else begin
                    n_state = ST_DONE;
                end
            end

            ST_RD: begin
                mem_req.re = 1'b1;
                n_state    = ST_WR;
            end

            ST_WR: begin
                n_res.in_map = 1'b1;
                if (r_cmd == ptog_pkg::CMD_POINT) begin
                    n_res.cell_index = ptog_pkg::IDX_W'(r_cidx);
                    n_res.cell_value = ptog_pkg::CELL_OCCUPIED;
                    if (!cur_bit) begin
                        mem_req.we    = 1'b1;
                        mem_req.wdata = mem_rdata
                            | (ptog_pkg::WORD_W'(1) << r_cidx[ptog_pkg::WBIT_W-1:0]);
                        n_res.newly_occupied = 1'b1;
                        if (r_count != ptog_pkg::COUNT_MAX) begin
                            n_count = r_count + 1'b1;
                        end
                    end
                end else begin
                    n_res.cell_value = cur_bit ? ptog_pkg::CELL_OCCUPIED
                                               : ptog_pkg::CELL_UNKNOWN;
                end
                n_state = ST_DONE;
            end

            ST_DONE: begin
                // Wait here only while an earlier result is still unclaimed.
                if (!r_out_valid || i_out_ready) begin
                    n_out              = r_res;
                    n_out.marked_cells = r_count;
                    n_out_valid        = 1'b1;
                    n_state            = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_count     <= '0;
            r_clr_addr  <= '0;
            r_clr_reply <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_clr_addr  <= n_clr_addr;
            r_clr_reply <= n_clr_reply;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_px   <= n_px;
        r_py   <= n_py;
        r_ridx <= n_ridx;
        r_axis <= n_axis;
        r_gx   <= n_gx;
        r_cidx <= n_cidx;
        r_res  <= n_res;
        r_out  <= n_out;
    end

endmodule
